// ===== src/mbmq_pkg.sv =====
package mbmq_pkg;

	localparam int BOX_TOTAL   = 11;
	localparam int INBOX_TOTAL = 6;
	localparam int EVENT_TOTAL = 5;
	localparam int BOX_W       = 4;
	localparam int EVENT_W     = 3;
	localparam int FIELD_MSG_W = 32;

	localparam logic [2:0] REC_INPUT   = 3'd4;
	localparam logic [2:0] REC_PHYSICS = 3'd5;
	localparam logic [2:0] REC_LAST    = 3'd5;

	typedef enum logic [1:0] {
		CMD_PUSH       = 2'd0,
		CMD_POP        = 2'd1,
		CMD_READ_EVENT = 2'd2,
		CMD_CLEAR      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_MISS   = 2'd1,
		ST_NO_BOX = 2'd2
	} status_t;

	typedef struct packed {
		logic               found;
		logic [BOX_W-1:0]   box;
		logic [EVENT_W-1:0] ev_idx;
	} box_sel_t;

	function automatic box_sel_t box_of(input logic [2:0] recipient, input logic event_kind);
		box_sel_t sel;
		sel.found  = 1'b1;
		sel.box    = BOX_W'(recipient);
		sel.ev_idx = '0;
		if (recipient > REC_LAST) begin
			sel.found = 1'b0;
			sel.box   = '0;
		end else if (event_kind) begin
			if (recipient == REC_INPUT) begin
				sel.found = 1'b0;
				sel.box   = '0;
			end else if (recipient == REC_PHYSICS) begin
				sel.ev_idx = EVENT_W'(EVENT_TOTAL - 1);
				sel.box    = BOX_W'(INBOX_TOTAL + EVENT_TOTAL - 1);
			end else begin
				sel.ev_idx = EVENT_W'(recipient);
				sel.box    = BOX_W'(INBOX_TOTAL) + BOX_W'(recipient);
			end
		end
		return sel;
	endfunction

endpackage

// ===== src/mbmq_if.sv =====
interface mbmq_req_if;
	logic                                 valid;
	logic                                 ready;
	mbmq_pkg::cmd_t                       command;
	logic [2:0]                           recipient;
	logic                                 box_kind;
	logic [7:0]                           entry_offset;
	logic [mbmq_pkg::FIELD_MSG_W-1:0]     message_in;

	modport source (output valid, command, recipient, box_kind, entry_offset, message_in,
		input ready);
	modport sink (input valid, command, recipient, box_kind, entry_offset, message_in,
		output ready);
endinterface

interface mbmq_rsp_if;
	logic                                 valid;
	logic                                 ready;
	mbmq_pkg::status_t                    status;
	logic [mbmq_pkg::FIELD_MSG_W-1:0]     message_out;

	modport source (output valid, status, message_out, input ready);
	modport sink (input valid, status, message_out, output ready);
endinterface

// ===== src/mbmq_store.sv =====
module mbmq_store #(
	parameter int WORDS = 176,
	parameter int AW    = 8,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [WORDS];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/multi_box_message_queue.sv =====
// channel   | dir | fields
// ----------+-----+-------------------------------------------------------------
// request   | in  | command, recipient, box_kind, entry_offset, message_in
// response  | out | status, message_out
//
// one beat per cycle unless the response stalls; a request passes the input
// register, then the response register; the input register feeds box decode
// and pointer logic, the store read is registered with the response
// arst_n clears all head, tail and event counts; the store is not cleared
// a stalled response holds the pipe; request ready stays high while either
// stage is free or the response moves
module multi_box_message_queue #(
	parameter int QUEUE_DEPTH   = 16,
	parameter int MESSAGE_WIDTH = 32
) (
	input logic            clk,
	input logic            arst_n,
	mbmq_req_if.sink       request,
	mbmq_rsp_if.source     response
);

	localparam int PW    = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int WORDS = mbmq_pkg::BOX_TOTAL * QUEUE_DEPTH;
	localparam int AW    = $clog2(WORDS);
	localparam int SW    = (MESSAGE_WIDTH < mbmq_pkg::FIELD_MSG_W) ? MESSAGE_WIDTH
		: mbmq_pkg::FIELD_MSG_W;

	logic                     v_s1;
	mbmq_pkg::cmd_t           cmd_s1;
	logic [2:0]               rec_s1;
	logic                     kind_s1;
	logic [7:0]               off_s1;
	logic [SW-1:0]            msg_s1;

	logic                     v_s2;
	mbmq_pkg::status_t        status_s2;
	logic                     use_rd_s2;

	logic [PW-1:0]            head_q [mbmq_pkg::BOX_TOTAL];
	logic [PW-1:0]            tail_q [mbmq_pkg::BOX_TOTAL];
	logic [PW-1:0]            cnt_q  [mbmq_pkg::EVENT_TOTAL];

	logic                     adv;
	logic                     fire1;
	logic                     ev;
	mbmq_pkg::box_sel_t       sel;
	logic [PW-1:0]            head_rd;
	logic [PW-1:0]            tail_rd;
	logic [PW-1:0]            cnt_rd;
	logic [PW-1:0]            head_nx;
	logic [PW-1:0]            tail_nx;
	logic [PW:0]              slot_sum;
	logic [PW-1:0]            slot;
	logic [PW-1:0]            rd_slot;
	logic                     full;
	logic                     empty;
	logic                     beyond;
	mbmq_pkg::status_t        status;
	logic                     we;
	logic                     re;
	logic [AW-1:0]            base;
	logic [AW-1:0]            waddr;
	logic [AW-1:0]            raddr;
	logic [SW-1:0]            rdata;

	assign adv           = !v_s2 || response.ready;
	assign request.ready = !v_s1 || adv;
	assign fire1         = v_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (request.ready) begin
			v_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			cmd_s1  <= request.command;
			rec_s1  <= request.recipient;
			kind_s1 <= request.box_kind;
			off_s1  <= request.entry_offset;
			msg_s1  <= request.message_in[SW-1:0];
		end
	end

	// box decode and queue state
	always_comb begin
		case (cmd_s1)
			mbmq_pkg::CMD_PUSH: ev = kind_s1;
			mbmq_pkg::CMD_POP:  ev = 1'b0;
			default:            ev = 1'b1;
		endcase
	end

	assign sel     = mbmq_pkg::box_of(rec_s1, ev);
	assign head_rd = head_q[sel.box];
	assign tail_rd = tail_q[sel.box];
	assign cnt_rd  = cnt_q[sel.ev_idx];

	assign head_nx = (head_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : head_rd + 1'b1;
	assign tail_nx = (tail_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_rd + 1'b1;
	assign full    = head_nx == tail_rd;
	assign empty   = head_rd == tail_rd;
	assign beyond  = off_s1 >= 8'(cnt_rd);

	// offset is below count when used, so one wrap is enough
	assign slot_sum = (PW + 1)'(tail_rd) + (PW + 1)'(off_s1[PW-1:0]);
	assign slot     = (slot_sum >= (PW + 1)'(QUEUE_DEPTH))
		? PW'(slot_sum - (PW + 1)'(QUEUE_DEPTH)) : PW'(slot_sum);
	assign rd_slot  = (cmd_s1 == mbmq_pkg::CMD_POP) ? tail_rd : slot;

	assign base  = AW'(sel.box) * AW'(QUEUE_DEPTH);
	assign waddr = base + AW'(head_rd);
	assign raddr = base + AW'(rd_slot);

	always_comb begin
		status = mbmq_pkg::ST_OK;
		if (!sel.found) begin
			status = mbmq_pkg::ST_NO_BOX;
		end else begin
			case (cmd_s1)
				mbmq_pkg::CMD_PUSH:       status = full ? mbmq_pkg::ST_MISS : mbmq_pkg::ST_OK;
				mbmq_pkg::CMD_POP:        status = empty ? mbmq_pkg::ST_MISS : mbmq_pkg::ST_OK;
				mbmq_pkg::CMD_READ_EVENT: status = beyond ? mbmq_pkg::ST_MISS : mbmq_pkg::ST_OK;
				default:                  status = mbmq_pkg::ST_OK;
			endcase
		end
	end

	assign we = fire1 && (status == mbmq_pkg::ST_OK) && (cmd_s1 == mbmq_pkg::CMD_PUSH);
	assign re = fire1 && (status == mbmq_pkg::ST_OK)
		&& ((cmd_s1 == mbmq_pkg::CMD_POP) || (cmd_s1 == mbmq_pkg::CMD_READ_EVENT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mbmq_pkg::BOX_TOTAL; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
			for (int i = 0; i < mbmq_pkg::EVENT_TOTAL; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (fire1 && (status == mbmq_pkg::ST_OK)) begin
			case (cmd_s1)
				mbmq_pkg::CMD_PUSH: begin
					head_q[sel.box] <= head_nx;
					if (ev) begin
						cnt_q[sel.ev_idx] <= cnt_rd + 1'b1;
					end
				end
				mbmq_pkg::CMD_POP: begin
					tail_q[sel.box] <= tail_nx;
				end
				mbmq_pkg::CMD_CLEAR: begin
					head_q[sel.box]   <= '0;
					tail_q[sel.box]   <= '0;
					cnt_q[sel.ev_idx] <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	mbmq_store #(
		.WORDS (WORDS),
		.AW    (AW),
		.DW    (SW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (msg_s1),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			status_s2 <= status;
			use_rd_s2 <= re;
		end
	end

	assign response.valid       = v_s2;
	assign response.status      = status_s2;
	assign response.message_out = use_rd_s2 ? mbmq_pkg::FIELD_MSG_W'(rdata) : '0;

	// event boxes are never popped, so their tail stays at zero
	a_event_tail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && sel.found && ev) |-> (tail_rd == '0))
		else $error("event box tail moved");

	a_event_count_head: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && sel.found && ev) |-> (cnt_rd == head_rd))
		else $error("event count out of step with head");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(we && ev) |=> (cnt_q[$past(sel.ev_idx)] == $past(cnt_rd) + 1'b1))
		else $error("event count not bumped on push");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fire1 && sel.found && (cmd_s1 == mbmq_pkg::CMD_CLEAR))
		|=> (head_q[$past(sel.box)] == '0) && (cnt_q[$past(sel.ev_idx)] == '0))
		else $error("clear left box state");

	a_no_rd_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(fire1 && (status != mbmq_pkg::ST_OK)) |-> (!we && !re))
		else $error("store touched on rejected beat");

endmodule
